// ===== hdl/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  // initial hash values, element 0 is the most significant digest word
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round constants, one per group of twenty rounds
  localparam logic [3:0][31:0] SHA1_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int unsigned BLK_SIZE    = 64;
  localparam int unsigned LEN_BYTE    = 56;
  localparam int unsigned LAST_ROUND  = 79;
  localparam int unsigned DIGEST_LAST = 4;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PADCHK,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_FIN,
    ST_OUT
  } state_t;

  // where the controller goes after a compression
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_OUT
  } phase_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       ins_left;
    logic       ins_pad;
    logic       put_len;
    logic       init;
    logic       round;
    logic       fin;
    logic       emit;
    logic       restart;
    logic [6:0] rnd;
    logic [2:0] idx;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic over_len;
    logic left_pend;
    logic last_pend;
    logic out_free;
  } status_t;

  // round function for the given group of twenty rounds
  function automatic logic [31:0] sha1_f(input logic [31:0] b, input logic [31:0] c,
                                         input logic [31:0] d, input logic [1:0] grp);
    logic [31:0] res;
    case (grp)
      2'd0:    res = (b & c) | (~b & d);
      2'd2:    res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_ctrl.sv =====
`default_nettype none

module sha1_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sha1_pkg::status_t st,
  output sha1_pkg::cmd_t         cmd
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::phase_t ph_r, ph_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [2:0]       idx_r, idx_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      ph_r    <= sha1_pkg::PH_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;

    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (st.full) begin
          ph_nxt    = sha1_pkg::PH_IDLE;
          state_nxt = sha1_pkg::ST_INIT;
        end else if (st.left_pend) begin
          cmd.ins_left = 1'b1;
        end else if (st.last_pend) begin
          cmd.ins_pad = 1'b1;
          state_nxt   = sha1_pkg::ST_PADCHK;
        end else begin
          in_ready    = 1'b1;
          cmd.load_in = in_valid;
        end
      end
      sha1_pkg::ST_PADCHK: begin
        // no room for the length field: run a block of zero fill first
        if (st.full || st.over_len) begin
          ph_nxt    = sha1_pkg::PH_LEN;
          state_nxt = sha1_pkg::ST_INIT;
        end else begin
          state_nxt = sha1_pkg::ST_LEN;
        end
      end
      sha1_pkg::ST_LEN: begin
        cmd.put_len = 1'b1;
        ph_nxt      = sha1_pkg::PH_OUT;
        state_nxt   = sha1_pkg::ST_INIT;
      end
      sha1_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'(sha1_pkg::LAST_ROUND)) begin
          state_nxt = sha1_pkg::ST_FIN;
        end
      end
      sha1_pkg::ST_FIN: begin
        cmd.fin = 1'b1;
        unique case (ph_r)
          sha1_pkg::PH_LEN: state_nxt = sha1_pkg::ST_LEN;
          sha1_pkg::PH_OUT: state_nxt = sha1_pkg::ST_OUT;
          default:          state_nxt = sha1_pkg::ST_IDLE;
        endcase
      end
      sha1_pkg::ST_OUT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == 3'(sha1_pkg::DIGEST_LAST)) begin
            cmd.restart = 1'b1;
            idx_nxt     = '0;
            state_nxt   = sha1_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sha1_dp.sv =====
`default_nettype none

module sha1_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sha1_pkg::cmd_t cmd,
  output sha1_pkg::status_t   st,
  input  wire logic [31:0]    in_data_word,
  input  wire logic [2:0]     in_byte_count,
  input  wire logic           in_last_word,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_of_digest
);

  logic [31:0] s_r     [16];
  logic [31:0] s_nxt   [16];
  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  logic [31:0] w_r     [5];
  logic [31:0] w_nxt   [5];
  logic [63:0] len_r, len_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [31:0] left_r, left_nxt;
  logic [2:0]  left_n_r, left_n_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  // insertion and round signals
  logic [2:0]  cnt;
  logic        ins_en;
  logic [31:0] ins_bytes;
  logic [2:0]  ins_n;
  logic [6:0]  sum;
  logic [1:0]  room;
  logic [1:0]  grp;
  logic [31:0] f_val;
  logic [31:0] tmp;
  logic [31:0] w_new;

  // byte count saturates at a full word
  assign cnt = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;

  // bytes to place into the block buffer this cycle
  always_comb begin
    ins_en    = cmd.load_in | cmd.ins_left | cmd.ins_pad;
    ins_bytes = in_data_word;
    ins_n     = cnt;
    if (cmd.ins_left) begin
      ins_bytes = left_r;
      ins_n     = left_n_r;
    end else if (cmd.ins_pad) begin
      ins_bytes = {sha1_pkg::PAD_BYTE, 24'h0};
      ins_n     = 3'd1;
    end
  end

  assign sum  = fill_r + {4'b0, ins_n};
  assign room = 2'(7'(sha1_pkg::BLK_SIZE) - fill_r);

  // round function and schedule expansion
  always_comb begin
    if (cmd.rnd < 7'd20) begin
      grp = 2'd0;
    end else if (cmd.rnd < 7'd40) begin
      grp = 2'd1;
    end else if (cmd.rnd < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
  end

  assign f_val = sha1_pkg::sha1_f(w_r[1], w_r[2], w_r[3], grp);
  assign tmp   = {w_r[0][26:0], w_r[0][31:27]} + f_val + w_r[4] + sha1_pkg::SHA1_K[grp]
                 + s_r[0];
  assign w_new = s_r[13] ^ s_r[8] ^ s_r[2] ^ s_r[0];

  // next values of all datapath registers
  always_comb begin
    logic [6:0] pos;
    pos           = '0;
    s_nxt         = s_r;
    chain_nxt     = chain_r;
    w_nxt         = w_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    left_n_nxt    = left_n_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    // byte placement at the fill position, overflow kept for the next block
    if (ins_en) begin
      for (int i = 0; i < 4; i++) begin
        pos = fill_r + 7'(i);
        if ((3'(i) < ins_n) && (pos < 7'(sha1_pkg::BLK_SIZE))) begin
          s_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = ins_bytes[8 * (3 - i) +: 8];
        end
      end
      if (sum > 7'(sha1_pkg::BLK_SIZE)) begin
        fill_nxt   = 7'(sha1_pkg::BLK_SIZE);
        left_n_nxt = 3'(sum - 7'(sha1_pkg::BLK_SIZE));
        left_nxt   = ins_bytes << {room, 3'b000};
      end else begin
        fill_nxt   = sum;
        left_n_nxt = '0;
      end
    end
    if (cmd.load_in) begin
      len_nxt  = len_r + {58'b0, cnt, 3'b000};
      last_nxt = in_last_word;
    end
    if (cmd.ins_pad) begin
      last_nxt = 1'b0;
    end

    // length field in the last two words
    if (cmd.put_len) begin
      s_nxt[14] = len_r[63:32];
      s_nxt[15] = len_r[31:0];
    end

    // compression
    if (cmd.init) begin
      w_nxt = chain_r;
    end
    if (cmd.round) begin
      w_nxt[4] = w_r[3];
      w_nxt[3] = w_r[2];
      w_nxt[2] = {w_r[1][1:0], w_r[1][31:2]};
      w_nxt[1] = w_r[0];
      w_nxt[0] = tmp;
      for (int i = 0; i < 15; i++) begin
        s_nxt[i] = s_r[i + 1];
      end
      s_nxt[15] = {w_new[30:0], w_new[31]};
    end
    if (cmd.fin) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + w_r[i];
      end
      for (int i = 0; i < 16; i++) begin
        s_nxt[i] = '0;
      end
      fill_nxt = '0;
    end

    // digest output and fresh start for the next message
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = chain_r[cmd.idx];
      out_idx_nxt   = cmd.idx;
      out_last_nxt  = (cmd.idx == 3'(sha1_pkg::DIGEST_LAST));
    end
    if (cmd.restart) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = sha1_pkg::SHA1_IV[i];
      end
      len_nxt = '0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        s_r[i] <= '0;
      end
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= sha1_pkg::SHA1_IV[i];
      end
      len_r       <= '0;
      fill_r      <= '0;
      left_n_r    <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_r         <= s_nxt;
      chain_r     <= chain_nxt;
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      left_n_r    <= left_n_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    left_r     <= left_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // status back to the controller
  assign st.full      = (fill_r == 7'(sha1_pkg::BLK_SIZE));
  assign st.over_len  = (fill_r > 7'(sha1_pkg::LEN_BYTE));
  assign st.left_pend = (left_n_r != 3'd0);
  assign st.last_pend = last_r;
  assign st.out_free  = ~out_valid_r | out_ready;

  assign out_valid          = out_valid_r;
  assign out_digest_word    = out_word_r;
  assign out_word_index     = out_idx_r;
  assign out_last_of_digest = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/sha1_hash_engine.sv =====
// SHA-1 hash engine.
// Input channel (in_valid/in_ready): one transfer carries a big-endian message
// word, its count of valid leading bytes (values above 4 count as 4) and a flag
// on the final word of the message. Bytes pack as one continuous stream.
// Output channel (out_valid/out_ready): after the final word, five transfers give
// the digest, word_index 0 to 4, last_of_digest set on the fifth.
// Throughput: a word is taken every cycle while the 64-byte block fills; a full
// block then holds off input through the full check, load, 80 rounds one per
// cycle and chaining add; leftover bytes of a word that overran the block go in
// before the next word is taken. After the final word, the pad byte and the
// length field go in and the last block is compressed before the first digest
// word; an extra block of zero fill runs first when the length field does not
// fit, and a final word that fills the block runs that block first.
// Reset (rst_n low, synchronous) loads the initial hash values, empties the block
// and the bit count and drops out_valid.
// A stalled receiver holds the digest word in the output register; the next
// word waits, and in_ready stays low until the fifth word is in that register.
`default_nettype none

module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_of_digest
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t st;

  // sequencer
  sha1_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // block buffer, rounds and digest
  sha1_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_data_word       (in_data_word),
    .in_byte_count      (in_byte_count),
    .in_last_word       (in_last_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digest_word    (out_digest_word),
    .out_word_index     (out_word_index),
    .out_last_of_digest (out_last_of_digest)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // sha-1 constants for the digest predictor
  localparam logic [4:0][31:0] HASH_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };
  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam int         BLOCK_LEN    = 64;
  localparam int         LEN_OFFSET   = 56;
  localparam int         DIGEST_WORDS = 5;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 200;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_of_digest;

  // predictor state
  logic [31:0] hash_state [DIGEST_WORDS];
  logic [31:0] block_words [16];
  int          block_fill;
  logic [63:0] msg_bits;

  digest_word_t pending_digest [$];
  int           mismatch_count = 0;
  int           words_sent = 0;
  int           idle_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;

  sha1_hash_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_word       (in_data_word),
    .in_byte_count      (in_byte_count),
    .in_last_word       (in_last_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digest_word    (out_digest_word),
    .out_word_index     (out_word_index),
    .out_last_of_digest (out_last_of_digest)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < DIGEST_WORDS; i++) hash_state[i] = HASH_IV[i];
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    block_fill = 0;
    msg_bits = '0;
  endfunction

  // 80 rounds over the held block, schedule expanded in place
  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, t;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        block_words[r % 16] = rotl(block_words[(r - 3) % 16] ^ block_words[(r - 8) % 16] ^
                                   block_words[(r - 14) % 16] ^ block_words[r % 16], 1);
      end
      case (r / 20)
        0:       f = (b & c) | (~b & d);
        2:       f = (b & c) | (b & d) | (c & d);
        default: f = b ^ c ^ d;
      endcase
      t = rotl(a, 5) + f + e + ROUND_K[r / 20] + block_words[r % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    block_fill = 0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int pos;
    pos = block_fill;
    block_words[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    block_fill = pos + 1;
    if (block_fill == BLOCK_LEN) compress_block();
  endfunction

  // digest prediction for one accepted word
  function automatic void predict_digest(input logic [31:0] data, input logic [2:0] count,
                                         input logic last);
    int n;
    digest_word_t dw;
    n = (count > 3'd4) ? 4 : int'(count);
    for (int i = 0; i < n; i++) begin
      absorb_byte(data[31 - 8 * i -: 8]);
      msg_bits += 64'd8;
    end
    if (!last) return;
    absorb_byte(PAD_MARK);
    if (block_fill > LEN_OFFSET) begin
      while (block_fill != 0) absorb_byte(8'h00);
    end
    while (block_fill < LEN_OFFSET) absorb_byte(8'h00);
    block_words[14] = msg_bits[63:32];
    block_words[15] = msg_bits[31:0];
    compress_block();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      dw.word  = hash_state[i];
      dw.index = 3'(i);
      dw.last  = (i == DIGEST_WORDS - 1);
      pending_digest.push_back(dw);
    end
    restart_message();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error at %0t: %s got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // digest checker and watchdog
  always @(posedge clk) begin
    digest_word_t dw;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_digest.size() == 0) begin
          report_mismatch("unexpected digest word", out_digest_word, 32'h0);
        end else begin
          dw = pending_digest.pop_front();
          if (out_digest_word !== dw.word)
            report_mismatch("digest_word", out_digest_word, dw.word);
          if (out_word_index !== dw.index)
            report_mismatch("word_index", 32'(out_word_index), 32'(dw.index));
          if (out_last_of_digest !== dw.last)
            report_mismatch("last_of_digest", 32'(out_last_of_digest), 32'(dw.last));
        end
      end
    end
  end

  // receiver: random stall bursts, ready stretches and one long hold-off
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 40);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // one input transfer, with an optional gap in front
  task automatic send_word(input logic [31:0] data, input logic [2:0] count, input logic last);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= count;
    in_last_word  <= last;
    do @(posedge clk); while (!in_ready);
    predict_digest(data, count, last);
    words_sent++;
  endtask

  // drop valid and wait for every pending digest word
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // message of random length, mostly full words with some short ones
  task automatic send_message(input int nwords);
    logic [2:0] count;
    for (int i = 0; i < nwords; i++) begin
      if (i == nwords - 1) count = 3'($urandom_range(0, 7));
      else if ($urandom_range(0, 7) == 0) count = 3'($urandom_range(0, 7));
      else count = 3'd4;
      send_word($urandom, count, i == nwords - 1);
    end
  endtask

  function automatic int random_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(1, 6);
    if (sel < 9) return $urandom_range(13, 18);
    return $urandom_range(28, 34);
  endfunction

  task automatic test_directed();
    // empty message
    send_word($urandom, 3'd0, 1'b1);
    // three-byte message with junk in the unused byte
    send_word({24'h616263, 8'($urandom)}, 3'd3, 1'b1);
    // data extremes
    send_word(32'hFFFFFFFF, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b1);
    // oversized counts
    send_word($urandom, 3'd7, 1'b0);
    send_word($urandom, 3'd5, 1'b1);
    // short and empty words in mid-message, then a last word with an oversized count
    send_word($urandom, 3'd1, 1'b0);
    send_word($urandom, 3'd2, 1'b0);
    send_word($urandom, 3'd3, 1'b0);
    send_word($urandom, 3'd0, 1'b0);
    send_word($urandom, 3'd6, 1'b1);
    // 55 bytes: padding and length just fit in one block
    for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
  endtask

  task automatic test_random_messages();
    int start;
    start = words_sent;
    while (words_sent - start < 200) send_message(random_length());
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(1, 4));
    wait_drained();
  endtask

  task automatic test_streaming();
    int start;
    no_idle = 1'b1;
    start = words_sent;
    while (words_sent - start < 40) send_message(random_length());
  endtask

  initial begin
    restart_message();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_messages();
    test_backpressure();
    test_streaming();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_digest.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sha1_pkg.sv
hdl/sha1_ctrl.sv
hdl/sha1_dp.sv
hdl/sha1_hash_engine.sv
tb/sv/testbench.sv
